[rtl/core/four_channel_pwm_generator_macros.svh]
// Assertion macros used by the PWM generator checker.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef FOUR_CHANNEL_PWM_GENERATOR_MACROS_SVH
`define FOUR_CHANNEL_PWM_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define PWM4_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pwm4 assertion failed");

// Next-cycle implication.
`define PWM4_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pwm4 assertion failed");

`endif

[rtl/core/pwm4_pkg.sv]
// Shared types and constants for the four-channel PWM generator.
// No dependencies.
`timescale 1ns / 1ps

package pwm4_pkg;

  localparam int CHANNELS    = 4;
  localparam int CHAN_W      = 2;
  localparam int COUNT_WIDTH = 32;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 5;
  localparam int OP_W        = 2;
  // Byte offset bit that selects the period register within a channel.
  localparam int PERIOD_BIT  = 2;
  // Lowest byte offset bit of the channel number (stride of 8).
  localparam int CHAN_LSB    = 3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;

endpackage

[rtl/core/four_channel_pwm_generator.sv]
// Top level of the PWM generator; uses pwm4_pkg.
// Throughput: 1 word per cycle while in_stall is low; the limiting path is the
// per-channel counter increment and compare against the active period.
// A result register plus a one-word skid take one more word while a result
// waits; input stalls while the skid is full, including the cycle it drains.
// Synchronous reset clears the counts, channel registers and valid flags to
// zero and sets the channel levels high; the output registers are not reset.
`timescale 1ns / 1ps

module four_channel_pwm_generator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [pwm4_pkg::OP_W-1:0]            operation,
  input  logic [pwm4_pkg::ADDR_W-1:0]          address,
  input  logic [pwm4_pkg::DATA_W-1:0]          write_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pwm4_pkg::DATA_W-1:0]          read_data,
  output logic [pwm4_pkg::CHANNELS-1:0]        pwm_levels
);
  import pwm4_pkg::*;

  count_t prog_high [CHANNELS];
  count_t prog_period [CHANNELS];
  count_t act_high [CHANNELS];
  count_t act_period [CHANNELS];
  count_t counter [CHANNELS];
  logic [CHANNELS-1:0] levels;

  count_t prog_high_next [CHANNELS];
  count_t prog_period_next [CHANNELS];
  count_t act_high_next [CHANNELS];
  count_t act_period_next [CHANNELS];
  count_t counter_next [CHANNELS];
  logic [CHANNELS-1:0] levels_next;

  count_t tick_count [CHANNELS];
  logic [CHANNELS-1:0] tick_level;
  logic [CHANNELS-1:0] tick_load;

  logic [DATA_W-1:0] rd_word;
  logic [CHAN_W-1:0] chan;
  logic is_period;

  logic [DATA_W-1:0] skid_read_data;
  logic [CHANNELS-1:0] skid_levels;
  logic skid_valid;

  logic in_fire;
  logic out_free;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  assign chan      = address[CHAN_LSB +: CHAN_W];
  assign is_period = address[PERIOD_BIT];

  // Per-channel tick: level, advanced count and end-of-period load.
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      tick_count[c] = counter[c] + count_t'(1);
      if (act_period[c] == '0) begin
        tick_level[c] = 1'b1;
        tick_load[c]  = 1'b1;
      end else begin
        tick_level[c] = (counter[c] < act_high[c]);
        tick_load[c]  = (tick_count[c] >= act_period[c]);
      end
    end
  end

  always_comb begin
    prog_high_next   = prog_high;
    prog_period_next = prog_period;
    act_high_next    = act_high;
    act_period_next  = act_period;
    counter_next     = counter;
    levels_next      = levels;
    rd_word          = '0;
    if (in_fire) begin
      case (op_t'(operation))
        OP_WRITE: begin
          if (is_period) begin
            prog_period_next[chan] = write_data[COUNT_WIDTH-1:0];
          end else begin
            prog_high_next[chan] = write_data[COUNT_WIDTH-1:0];
          end
        end
        OP_READ: begin
          rd_word = is_period ? DATA_W'(prog_period[chan]) : DATA_W'(prog_high[chan]);
        end
        OP_TICK: begin
          levels_next = tick_level;
          for (int c = 0; c < CHANNELS; c++) begin
            if (tick_load[c]) begin
              act_high_next[c]   = prog_high[c];
              act_period_next[c] = prog_period[c];
              counter_next[c]    = '0;
            end else begin
              counter_next[c] = tick_count[c];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        prog_high[c]   <= '0;
        prog_period[c] <= '0;
        act_high[c]    <= '0;
        act_period[c]  <= '0;
        counter[c]     <= '0;
      end
      levels <= '1;
    end else begin
      prog_high   <= prog_high_next;
      prog_period <= prog_period_next;
      act_high    <= act_high_next;
      act_period  <= act_period_next;
      counter     <= counter_next;
      levels      <= levels_next;
    end
  end

  // Result register with skid: park the new word in the skid while the
  // result register is stalled, and drain the skid first once it frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        read_data  <= skid_read_data;
        pwm_levels <= skid_levels;
      end else if (in_fire) begin
        read_data  <= rd_word;
        pwm_levels <= levels_next;
      end
    end else if (in_fire) begin
      skid_read_data <= rd_word;
      skid_levels    <= levels_next;
    end
  end

endmodule

[rtl/core/pwm4_checker.sv]
// Port-level checker for the PWM generator, bound to the top level.
// Uses pwm4_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "four_channel_pwm_generator_macros.svh"

module pwm4_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [pwm4_pkg::OP_W-1:0]      operation,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [pwm4_pkg::DATA_W-1:0]    read_data,
  input logic [pwm4_pkg::CHANNELS-1:0]  pwm_levels
);
  import pwm4_pkg::*;

  logic in_fire;
  assign in_fire = in_valid && !in_stall;

  // A stalled result word holds.
  `PWM4_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_data) && $stable(pwm_levels))
  // A word taken into an empty output shows up on the next cycle.
  `PWM4_ASSERT_NXT(a_pass_through, in_fire && !out_valid, out_valid)
  // Only a read returns data.
  `PWM4_ASSERT_NXT(a_read_zero, in_fire && !out_valid && operation != OP_READ, read_data == '0)
  // A word taken behind a stalled result fills the skid and stalls input.
  `PWM4_ASSERT_NXT(a_skid_fill, in_fire && out_valid && out_stall, in_stall)

endmodule

bind four_channel_pwm_generator pwm4_checker u_pwm4_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .operation  (operation),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .read_data  (read_data),
  .pwm_levels (pwm_levels)
);
